[design/fsrm_pkg.sv]
// Package for the frame slot ring manager: types, codes, sizes and helpers.
`default_nettype none
package fsrm_pkg;

	// Ring size and derived widths
	localparam int SLOT_COUNT = 4;
	localparam int PTR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	// Header size rule: need = HDR_FIXED_BYTES + w*bpp*(h + RESERVED_LINES)
	localparam int HDR_FIXED_BYTES = 6;
	localparam int RESERVED_LINES = 4;
	localparam int WB_W = 24;               // w * bpp
	localparam int LINES_W = 17;            // h + reserved lines
	localparam int PROD_W = WB_W + LINES_W; // w * bpp * (h + reserved)
	localparam int NEED_W = PROD_W + 1;     // plus fixed header bytes

	typedef enum logic [1:0] {
		REQ_PUSH = 2'd0,
		REQ_DEQUEUE = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_RSVD = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_STORED = 3'd0,
		ST_REJECTED = 3'd1,
		ST_DROPPED = 3'd2,
		ST_GIVEN = 3'd3,
		ST_EMPTY = 3'd4,
		ST_RELEASED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_READ,
		S_RESP
	} state_t;

	// Request word
	typedef struct packed {
		req_type_t req_type;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [7:0] bytes_per_pixel;
		logic [7:0] pixel_format;
		logic [31:0] payload_length;
		logic [63:0] frame_time;
		logic [1:0] release_slot;
	} req_word_t;

	// Response word
	typedef struct packed {
		status_t status;
		logic [1:0] slot_index;
		logic [15:0] out_width;
		logic [15:0] out_height;
		logic [7:0] out_bpp;
		logic [7:0] out_format;
		logic [63:0] out_time;
	} rsp_word_t;

	// Per-slot metadata held in the slot memory
	typedef struct packed {
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0] bpp;
		logic [7:0] format;
		logic [63:0] time_stamp;
	} meta_t;

	// Advance a ring pointer with wrap
	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(SLOT_COUNT - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[design/fsrm_meta_ram.sv]
// Generic single-port-write, registered-read RAM for slot metadata.
`default_nettype none
module fsrm_meta_ram #(
	parameter int DEPTH = 4,
	parameter int ADDR_W = 2,
	parameter int DATA_W = 112
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [ADDR_W-1:0] waddr,
	input wire logic [DATA_W-1:0] wdata,
	input wire logic re,
	input wire logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered output
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[design/frame_slot_ring_manager_top.sv]
// Top level of the frame slot ring manager: request sequencer, ring state and response register.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one request word: push a
//   frame header, dequeue the oldest frame, or release a held slot.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one response word
//   per request, in request order.
// Steps: a push walks two registered multiplies for the length check, then
//   the ring update; a dequeue waits for the metadata memory read; release
//   and unknown codes go straight to the response step.
// The sequencer takes one request at a time: a new request is accepted only
//   after the previous one has walked those steps.
// The response sits in an output register; the next request is accepted
//   while it waits. If rsp_ready stays low, the following request finishes
//   its work and holds in its last step until the output register frees.
// Reset (arst_n low): pointers, frame count and hold marks clear, no
//   response is pending. Slot metadata is not cleared; a dequeue only
//   reads slots that a push wrote.
`default_nettype none
module frame_slot_ring_manager_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire fsrm_pkg::req_word_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output fsrm_pkg::rsp_word_t rsp
);

	localparam int PW = fsrm_pkg::PTR_W;
	localparam int DEPTH = fsrm_pkg::SLOT_COUNT;

	fsrm_pkg::state_t state_q, state_d;
	fsrm_pkg::req_word_t req_q;
	logic [fsrm_pkg::WB_W-1:0] wb_s1;
	logic [fsrm_pkg::PROD_W-1:0] prod_s2;
	logic [PW-1:0] rp_q, rp_d, wp_q, wp_d;
	logic [fsrm_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [DEPTH-1:0] held_q, held_d;
	fsrm_pkg::rsp_word_t rsp_q, rsp_d;
	logic rsp_valid_q;
	logic fire;

	// Metadata memory interface
	logic mem_we, mem_re;
	logic [PW-1:0] mem_waddr;
	fsrm_pkg::meta_t mem_wdata, mem_rdata;
	logic [$bits(fsrm_pkg::meta_t)-1:0] mem_rdata_raw;

	fsrm_meta_ram #(
		.DEPTH(DEPTH),
		.ADDR_W(PW),
		.DATA_W($bits(fsrm_pkg::meta_t))
	) u_meta_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(rp_q),
		.rdata(mem_rdata_raw)
	);

	assign mem_rdata = mem_rdata_raw;
	assign mem_re = (state_q == fsrm_pkg::S_READ);

	assign req_ready = (state_q == fsrm_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Final step fires once the output register is free
	assign fire = (state_q == fsrm_pkg::S_RESP) && (!rsp_valid_q || rsp_ready);

	// Length check: need = 6 + w*bpp*(h + 4)
	logic [fsrm_pkg::NEED_W-1:0] need;
	logic hdr_bad;
	assign need = {1'b0, prod_s2} + fsrm_pkg::NEED_W'(fsrm_pkg::HDR_FIXED_BYTES);
	assign hdr_bad = (req_q.frame_width == '0) || (req_q.frame_height == '0) ||
			(req_q.bytes_per_pixel == '0) ||
			({{(fsrm_pkg::NEED_W - 32){1'b0}}, req_q.payload_length} < need);

	// Eviction scan: first unheld slot walking from the read pointer
	logic evict_found;
	logic [PW-1:0] victim_slot;
	always_comb begin
		logic [PW:0] sum;
		evict_found = 1'b0;
		victim_slot = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sum = {1'b0, rp_q} + (PW + 1)'(i);
			if (sum >= (PW + 1)'(DEPTH)) begin
				sum = sum - (PW + 1)'(DEPTH);
			end
			if (!evict_found && !held_q[sum[PW-1:0]]) begin
				evict_found = 1'b1;
				victim_slot = sum[PW-1:0];
			end
		end
	end

	// Next state, ring update and response
	always_comb begin
		logic full;
		logic [PW-1:0] target;
		logic [PW-1:0] rel_idx;
		state_d = state_q;
		rp_d = rp_q;
		wp_d = wp_q;
		cnt_d = cnt_q;
		held_d = held_q;
		rsp_d = '0;
		mem_we = 1'b0;
		mem_waddr = wp_q;
		mem_wdata.width = req_q.frame_width;
		mem_wdata.height = req_q.frame_height;
		mem_wdata.bpp = req_q.bytes_per_pixel;
		mem_wdata.format = req_q.pixel_format;
		mem_wdata.time_stamp = req_q.frame_time;
		full = (cnt_q == fsrm_pkg::CNT_W'(DEPTH));
		target = full ? victim_slot : wp_q;
		rel_idx = PW'(req_q.release_slot);

		unique case (state_q)
			fsrm_pkg::S_IDLE: begin
				if (req_valid) begin
					unique case (req.req_type)
						fsrm_pkg::REQ_PUSH: state_d = fsrm_pkg::S_MUL1;
						fsrm_pkg::REQ_DEQUEUE: state_d = fsrm_pkg::S_READ;
						default: state_d = fsrm_pkg::S_RESP;
					endcase
				end
			end
			fsrm_pkg::S_MUL1: state_d = fsrm_pkg::S_MUL2;
			fsrm_pkg::S_MUL2: state_d = fsrm_pkg::S_RESP;
			fsrm_pkg::S_READ: state_d = fsrm_pkg::S_RESP;
			fsrm_pkg::S_RESP: begin
				if (fire) begin
					state_d = fsrm_pkg::S_IDLE;
					unique case (req_q.req_type)
						fsrm_pkg::REQ_PUSH: begin
							if (hdr_bad) begin
								rsp_d.status = fsrm_pkg::ST_REJECTED;
							end else if (full && !evict_found) begin
								rsp_d.status = fsrm_pkg::ST_DROPPED;
							end else begin
								// Full ring: eviction and store leave the count as is
								if (full) begin
									if (victim_slot == rp_q) begin
										rp_d = fsrm_pkg::ring_next(rp_q);
									end
								end else begin
									cnt_d = cnt_q + 1'b1;
								end
								mem_we = 1'b1;
								mem_waddr = target;
								held_d[target] = 1'b0;
								wp_d = fsrm_pkg::ring_next(wp_q);
								rsp_d.status = fsrm_pkg::ST_STORED;
								rsp_d.slot_index = 2'(target);
							end
						end
						fsrm_pkg::REQ_DEQUEUE: begin
							if (cnt_q == '0) begin
								rsp_d.status = fsrm_pkg::ST_EMPTY;
							end else begin
								held_d[rp_q] = 1'b1;
								rp_d = fsrm_pkg::ring_next(rp_q);
								cnt_d = cnt_q - 1'b1;
								rsp_d.status = fsrm_pkg::ST_GIVEN;
								rsp_d.slot_index = 2'(rp_q);
								rsp_d.out_width = mem_rdata.width;
								rsp_d.out_height = mem_rdata.height;
								rsp_d.out_bpp = mem_rdata.bpp;
								rsp_d.out_format = mem_rdata.format;
								rsp_d.out_time = mem_rdata.time_stamp;
							end
						end
						fsrm_pkg::REQ_RELEASE: begin
							// Index beyond the ring is ignored
							if (32'(req_q.release_slot) < 32'(DEPTH)) begin
								held_d[rel_idx] = 1'b0;
							end
							rsp_d.status = fsrm_pkg::ST_RELEASED;
						end
						default: rsp_d.status = fsrm_pkg::ST_REJECTED;
					endcase
				end
			end
			default: state_d = fsrm_pkg::S_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsrm_pkg::S_IDLE;
			rp_q <= '0;
			wp_q <= '0;
			cnt_q <= '0;
			held_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_q <= rp_d;
			wp_q <= wp_d;
			cnt_q <= cnt_d;
			held_q <= held_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: captured request, multiply steps, response word
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == fsrm_pkg::S_MUL1) begin
			wb_s1 <= fsrm_pkg::WB_W'(req_q.frame_width) * fsrm_pkg::WB_W'(req_q.bytes_per_pixel);
		end
		if (state_q == fsrm_pkg::S_MUL2) begin
			prod_s2 <= fsrm_pkg::PROD_W'(wb_s1) *
					fsrm_pkg::PROD_W'(fsrm_pkg::LINES_W'(req_q.frame_height) +
					fsrm_pkg::LINES_W'(fsrm_pkg::RESERVED_LINES));
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
`default_nettype wire
